[rtl/ubxd_pkg.sv]
// Shared types, constants and the field layout table for the UBX frame decoder.
// Used by every module of the decoder; depends on nothing.
package ubxd_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 128;
    localparam int CMD_DEPTH         = 2;
    localparam int VALUE_W           = 33;
    localparam int FID_W             = 6;
    localparam int OUT_TDATA_W       = 40;

    localparam logic [7:0] SYNC_FIRST_RST    = 8'd181;
    localparam logic [7:0] SYNC_SECOND_RST   = 8'd98;
    localparam logic [7:0] CLASS_CODE_RST    = 8'd1;
    localparam logic [7:0] PVT_ID_RST        = 8'd7;
    localparam logic [7:0] RELPOS_ID_RST     = 8'd60;
    localparam logic [7:0] PVT_LENGTH_RST    = 8'd92;
    localparam logic [7:0] RELPOS_LENGTH_RST = 8'd64;

    localparam logic        KIND_PVT    = 1'b0;
    localparam logic        KIND_RELPOS = 1'b1;

    localparam int          YEAR_BASE    = 1980;
    localparam logic [7:0]  SEC_LIMIT    = 8'd60;
    localparam logic [7:0]  SEC_MAX      = 8'd59;
    localparam logic [31:0] DIV10_MAGIC  = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT  = 35;

    typedef enum logic [2:0] {
        REG_SYNC_FIRST, REG_SYNC_SECOND, REG_CLASS_CODE, REG_PVT_ID,
        REG_RELPOS_ID, REG_PVT_LENGTH, REG_RELPOS_LENGTH
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] class_code;
        logic [7:0] pvt_id;
        logic [7:0] relpos_id;
        logic [7:0] pvt_length;
        logic [7:0] relpos_length;
    } cfg_t;

    typedef enum logic [3:0] {
        PH_SYNC1, PH_SYNC2, PH_CLASS, PH_ID, PH_LENLO, PH_LENHI,
        PH_PAYLOAD, PH_CKA, PH_CKB
    } phase_t;

    typedef struct packed {
        logic kind;
        logic fail;
    } cmd_t;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } wr_t;

    typedef enum logic [2:0] {OP_U, OP_S, OP_BITS, OP_SEC, OP_DATE, OP_DIV} op_t;

    typedef enum logic [2:0] {
        CAP_NONE, CAP_YEAR, CAP_MONTH, CAP_DAY, CAP_HOUR, CAP_MIN, CAP_SEC
    } cap_t;

    typedef enum logic [2:0] {B_IDLE, B_RD, B_CAP, B_CALC, B_DIV, B_SEND} bst_t;

    typedef struct packed {
        logic [6:0] off;
        logic [2:0] nb;
        op_t        op;
        logic [3:0] sh;
        logic [2:0] mask;
        cap_t       cap;
        logic       last;
    } fld_t;

    function automatic fld_t mk(input logic [6:0] off, input logic [2:0] nb, input op_t op,
                                input logic [3:0] sh, input logic [2:0] mask,
                                input cap_t cap, input logic last);
        fld_t f;
        f.off  = off;
        f.nb   = nb;
        f.op   = op;
        f.sh   = sh;
        f.mask = mask;
        f.cap  = cap;
        f.last = last;
        return f;
    endfunction

    function automatic fld_t pvt_fld(input logic [FID_W-1:0] fid);
        fld_t f;
        f = mk(7'd0, 3'd4, OP_U, 4'd0, 3'd0, CAP_NONE, 1'b0);
        case (fid)
            6'd0:  f = mk(7'd0,  3'd4, OP_U,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd1:  f = mk(7'd4,  3'd2, OP_U,    4'd0, 3'd0, CAP_YEAR,  1'b0);
            6'd2:  f = mk(7'd6,  3'd1, OP_U,    4'd0, 3'd0, CAP_MONTH, 1'b0);
            6'd3:  f = mk(7'd7,  3'd1, OP_U,    4'd0, 3'd0, CAP_DAY,   1'b0);
            6'd4:  f = mk(7'd8,  3'd1, OP_U,    4'd0, 3'd0, CAP_HOUR,  1'b0);
            6'd5:  f = mk(7'd9,  3'd1, OP_U,    4'd0, 3'd0, CAP_MIN,   1'b0);
            6'd6:  f = mk(7'd10, 3'd1, OP_SEC,  4'd0, 3'd0, CAP_SEC,   1'b0);
            6'd7:  f = mk(7'd11, 3'd1, OP_DATE, 4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd8:  f = mk(7'd11, 3'd1, OP_BITS, 4'd0, 3'd1, CAP_NONE,  1'b0);
            6'd9:  f = mk(7'd11, 3'd1, OP_BITS, 4'd1, 3'd1, CAP_NONE,  1'b0);
            6'd10: f = mk(7'd11, 3'd1, OP_BITS, 4'd2, 3'd1, CAP_NONE,  1'b0);
            6'd11: f = mk(7'd11, 3'd1, OP_BITS, 4'd3, 3'd1, CAP_NONE,  1'b0);
            6'd12: f = mk(7'd12, 3'd4, OP_U,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd13: f = mk(7'd16, 3'd4, OP_S,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd14: f = mk(7'd20, 3'd1, OP_U,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd15: f = mk(7'd21, 3'd1, OP_BITS, 4'd0, 3'd1, CAP_NONE,  1'b0);
            6'd16: f = mk(7'd21, 3'd1, OP_BITS, 4'd1, 3'd1, CAP_NONE,  1'b0);
            6'd17: f = mk(7'd21, 3'd1, OP_BITS, 4'd2, 3'd7, CAP_NONE,  1'b0);
            6'd18: f = mk(7'd21, 3'd1, OP_BITS, 4'd5, 3'd1, CAP_NONE,  1'b0);
            6'd19: f = mk(7'd21, 3'd1, OP_BITS, 4'd6, 3'd3, CAP_NONE,  1'b0);
            6'd20: f = mk(7'd22, 3'd1, OP_BITS, 4'd5, 3'd1, CAP_NONE,  1'b0);
            6'd21: f = mk(7'd22, 3'd1, OP_BITS, 4'd6, 3'd1, CAP_NONE,  1'b0);
            6'd22: f = mk(7'd22, 3'd1, OP_BITS, 4'd7, 3'd1, CAP_NONE,  1'b0);
            6'd23: f = mk(7'd23, 3'd1, OP_U,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd24: f = mk(7'd24, 3'd4, OP_DIV,  4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd25: f = mk(7'd28, 3'd4, OP_DIV,  4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd26: f = mk(7'd32, 3'd4, OP_S,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd27: f = mk(7'd36, 3'd4, OP_S,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd28: f = mk(7'd40, 3'd4, OP_U,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd29: f = mk(7'd44, 3'd4, OP_U,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd30: f = mk(7'd48, 3'd4, OP_S,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd31: f = mk(7'd52, 3'd4, OP_S,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd32: f = mk(7'd56, 3'd4, OP_S,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd33: f = mk(7'd60, 3'd4, OP_S,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd34: f = mk(7'd64, 3'd4, OP_S,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd35: f = mk(7'd68, 3'd4, OP_U,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd36: f = mk(7'd72, 3'd4, OP_U,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd37: f = mk(7'd76, 3'd2, OP_U,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd38: f = mk(7'd78, 3'd1, OP_BITS, 4'd0, 3'd1, CAP_NONE,  1'b0);
            6'd39: f = mk(7'd84, 3'd4, OP_S,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd40: f = mk(7'd88, 3'd2, OP_S,    4'd0, 3'd0, CAP_NONE,  1'b0);
            6'd41: f = mk(7'd90, 3'd2, OP_U,    4'd0, 3'd0, CAP_NONE,  1'b1);
            default: f = mk(7'd90, 3'd2, OP_U,  4'd0, 3'd0, CAP_NONE,  1'b1);
        endcase
        return f;
    endfunction

    function automatic fld_t relpos_fld(input logic [FID_W-1:0] fid);
        fld_t f;
        f = mk(7'd0, 3'd1, OP_U, 4'd0, 3'd0, CAP_NONE, 1'b0);
        case (fid)
            6'd0:  f = mk(7'd0,  3'd1, OP_U,    4'd0, 3'd0, CAP_NONE, 1'b0);
            6'd1:  f = mk(7'd2,  3'd2, OP_U,    4'd0, 3'd0, CAP_NONE, 1'b0);
            6'd2:  f = mk(7'd4,  3'd4, OP_U,    4'd0, 3'd0, CAP_NONE, 1'b0);
            6'd3:  f = mk(7'd8,  3'd4, OP_S,    4'd0, 3'd0, CAP_NONE, 1'b0);
            6'd4:  f = mk(7'd12, 3'd4, OP_S,    4'd0, 3'd0, CAP_NONE, 1'b0);
            6'd5:  f = mk(7'd16, 3'd4, OP_S,    4'd0, 3'd0, CAP_NONE, 1'b0);
            6'd6:  f = mk(7'd20, 3'd4, OP_S,    4'd0, 3'd0, CAP_NONE, 1'b0);
            6'd7:  f = mk(7'd24, 3'd4, OP_S,    4'd0, 3'd0, CAP_NONE, 1'b0);
            6'd8:  f = mk(7'd32, 3'd1, OP_S,    4'd0, 3'd0, CAP_NONE, 1'b0);
            6'd9:  f = mk(7'd33, 3'd1, OP_S,    4'd0, 3'd0, CAP_NONE, 1'b0);
            6'd10: f = mk(7'd34, 3'd1, OP_S,    4'd0, 3'd0, CAP_NONE, 1'b0);
            6'd11: f = mk(7'd35, 3'd1, OP_S,    4'd0, 3'd0, CAP_NONE, 1'b0);
            6'd12: f = mk(7'd36, 3'd4, OP_U,    4'd0, 3'd0, CAP_NONE, 1'b0);
            6'd13: f = mk(7'd40, 3'd4, OP_U,    4'd0, 3'd0, CAP_NONE, 1'b0);
            6'd14: f = mk(7'd44, 3'd4, OP_U,    4'd0, 3'd0, CAP_NONE, 1'b0);
            6'd15: f = mk(7'd48, 3'd4, OP_U,    4'd0, 3'd0, CAP_NONE, 1'b0);
            6'd16: f = mk(7'd52, 3'd4, OP_U,    4'd0, 3'd0, CAP_NONE, 1'b0);
            6'd17: f = mk(7'd60, 3'd2, OP_BITS, 4'd0, 3'd1, CAP_NONE, 1'b0);
            6'd18: f = mk(7'd60, 3'd2, OP_BITS, 4'd1, 3'd1, CAP_NONE, 1'b0);
            6'd19: f = mk(7'd60, 3'd2, OP_BITS, 4'd2, 3'd1, CAP_NONE, 1'b0);
            6'd20: f = mk(7'd60, 3'd2, OP_BITS, 4'd3, 3'd3, CAP_NONE, 1'b0);
            6'd21: f = mk(7'd60, 3'd2, OP_BITS, 4'd5, 3'd1, CAP_NONE, 1'b0);
            6'd22: f = mk(7'd60, 3'd2, OP_BITS, 4'd6, 3'd1, CAP_NONE, 1'b0);
            6'd23: f = mk(7'd60, 3'd2, OP_BITS, 4'd7, 3'd1, CAP_NONE, 1'b0);
            6'd24: f = mk(7'd60, 3'd2, OP_BITS, 4'd8, 3'd1, CAP_NONE, 1'b0);
            6'd25: f = mk(7'd60, 3'd2, OP_BITS, 4'd9, 3'd1, CAP_NONE, 1'b1);
            default: f = mk(7'd60, 3'd2, OP_BITS, 4'd9, 3'd1, CAP_NONE, 1'b1);
        endcase
        return f;
    endfunction

    function automatic fld_t fld_lookup(input logic kind, input logic [FID_W-1:0] fid);
        return (kind == KIND_RELPOS) ? relpos_fld(fid) : pvt_fld(fid);
    endfunction

endpackage

[rtl/ubxd_payload_ram.sv]
// Payload store: one write port from the parser, one registered read port for the field unit.
// Depends on ubxd_pkg.
module ubxd_payload_ram #(
    parameter int DEPTH = ubxd_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic             aclk,
    input  ubxd_pkg::wr_t    wr,
    input  logic [7:0]       rd_addr,
    output logic [7:0]       rd_data
);
    import ubxd_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [7:0] mem [DEPTH];
    logic [7:0] q_reg;
    logic       ok_reg;

    always_ff @(posedge aclk) begin
        if (wr.en && ({1'b0, wr.addr} < 9'(DEPTH))) begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
    end

    // reads past the store give zero
    always_ff @(posedge aclk) begin
        q_reg  <= mem[rd_addr[AW-1:0]];
        ok_reg <= ({1'b0, rd_addr} < 9'(DEPTH));
    end

    assign rd_data = ok_reg ? q_reg : 8'd0;

endmodule

[rtl/ubxd_cmd_fifo.sv]
// Two-entry request queue between the frame parser and the field unit.
// Depends on ubxd_pkg.
module ubxd_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ubxd_pkg::cmd_t push_cmd,
    input  logic           pop,
    output ubxd_pkg::cmd_t pop_cmd,
    output logic           full,
    output logic           empty
);
    import ubxd_pkg::*;

    cmd_t       slot_reg [CMD_DEPTH];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign pop_cmd = slot_reg[rptr_reg];
    assign full    = (cnt_reg == 2'(CMD_DEPTH));
    assign empty   = (cnt_reg == 2'd0);

endmodule

[rtl/ubxd_front.sv]
// Frame parser: header hunt, payload store writes, Fletcher-8 check, queues requests.
// Depends on ubxd_pkg.
module ubxd_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  ubxd_pkg::cfg_t cfg,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,
    input  logic           run_busy,
    input  logic           q_full,
    output ubxd_pkg::wr_t  wr,
    output logic           push,
    output ubxd_pkg::cmd_t push_cmd
);
    import ubxd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] sum_a_reg, sum_a_next;
    logic [7:0] sum_b_reg, sum_b_next;
    logic [7:0] count_reg, count_next;
    logic       kind_reg, kind_next;

    logic       storing, take;
    logic [7:0] b, len, a1, b1, cnt1;

    assign storing  = phase_reg inside {PH_PAYLOAD, PH_CKA, PH_CKB};
    // hold store writes while the field unit may still read the last frame
    assign s_tready = !q_full && !(storing && run_busy);
    assign take     = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign len      = kind_reg ? cfg.relpos_length : cfg.pvt_length;
    assign a1       = sum_a_reg + b;
    assign b1       = sum_b_reg + a1;
    assign cnt1     = count_reg + 8'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC1;
            sum_a_reg <= 8'd0;
            sum_b_reg <= 8'd0;
            count_reg <= 8'd0;
            kind_reg  <= KIND_PVT;
        end else begin
            phase_reg <= phase_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            count_reg <= count_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        count_next = count_reg;
        kind_next  = kind_reg;
        wr.en      = 1'b0;
        wr.addr    = count_reg;
        wr.data    = b;
        push       = 1'b0;
        push_cmd.kind = kind_reg;
        push_cmd.fail = 1'b1;
        if (take) begin
            case (phase_reg)
                PH_SYNC1: begin
                    phase_next = (b == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
                end
                PH_SYNC2: begin
                    phase_next = (b == cfg.sync_second) ? PH_CLASS : PH_SYNC1;
                end
                PH_CLASS: begin
                    if (b == cfg.class_code) begin
                        phase_next = PH_ID;
                        count_next = 8'd0;
                        sum_a_next = b;
                        sum_b_next = b;
                    end else begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_ID: begin
                    if (b == cfg.pvt_id || b == cfg.relpos_id) begin
                        kind_next  = (b == cfg.pvt_id) ? KIND_PVT : KIND_RELPOS;
                        sum_a_next = a1;
                        sum_b_next = b1;
                        phase_next = PH_LENLO;
                    end else begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_LENLO, PH_LENHI: begin
                    if (b == ((phase_reg == PH_LENLO) ? len : 8'd0)) begin
                        sum_a_next = a1;
                        sum_b_next = b1;
                        phase_next = (phase_reg == PH_LENLO) ? PH_LENHI : PH_PAYLOAD;
                    end else begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_PAYLOAD: begin
                    wr.en      = 1'b1;
                    count_next = cnt1;
                    sum_a_next = a1;
                    sum_b_next = b1;
                    if (cnt1 == len) phase_next = PH_CKA;
                end
                PH_CKA: begin
                    wr.en      = 1'b1;
                    count_next = cnt1;
                    if (b != sum_a_reg) begin
                        phase_next = PH_SYNC1;
                        push       = 1'b1;
                    end else begin
                        phase_next = PH_CKB;
                    end
                end
                PH_CKB: begin
                    wr.en         = 1'b1;
                    count_next    = cnt1;
                    phase_next    = PH_SYNC1;
                    push          = 1'b1;
                    push_cmd.fail = (b != sum_b_reg);
                end
                default: begin
                    phase_next = PH_SYNC1;
                end
            endcase
        end
    end

endmodule

[rtl/ubxd_back.sv]
// Field unit: pops requests, gathers each field's bytes from the store, shapes and sends it.
// Depends on ubxd_pkg.
module ubxd_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_empty,
    input  ubxd_pkg::cmd_t                 q_cmd,
    output logic                           pop,
    output logic                           idle,
    output logic [7:0]                     rd_addr,
    input  logic [7:0]                     rd_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ubxd_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);
    import ubxd_pkg::*;

    bst_t               st_reg, st_next;
    logic               kind_reg, kind_next;
    logic [FID_W-1:0]   fid_reg, fid_next;
    logic [1:0]         bidx_reg, bidx_next;
    logic [31:0]        acc_reg, acc_next;
    logic [6:0]         year_reg, year_next;
    logic [3:0]         mon_reg, mon_next;
    logic [4:0]         day_reg, day_next;
    logic [4:0]         hour_reg, hour_next;
    logic [5:0]         min_reg, min_next;
    logic [5:0]         sec_reg, sec_next;
    logic [63:0]        prod_reg, prod_next;
    logic               neg_reg, neg_next;
    logic               ovalid_reg, ovalid_next;
    logic [VALUE_W-1:0] oval_reg, oval_next;
    logic [FID_W-1:0]   ofid_reg, ofid_next;
    logic               okind_reg, okind_next;
    logic               ostat_reg, ostat_next;
    logic               olast_reg, olast_next;

    fld_t               ent;
    logic [31:0]        shifted, mag;
    logic [7:0]         secv;
    logic [28:0]        quot;
    logic [VALUE_W-1:0] calc;

    assign ent     = fld_lookup(kind_reg, fid_reg);
    assign rd_addr = {1'b0, ent.off} + {6'd0, bidx_reg};
    assign shifted = acc_reg >> ent.sh;
    assign secv    = (acc_reg[7:0] >= SEC_LIMIT) ? SEC_MAX : acc_reg[7:0];
    assign mag     = acc_reg[31] ? (32'd0 - acc_reg) : acc_reg;
    assign quot    = prod_reg[63:DIV10_SHIFT];

    always_comb begin
        case (ent.op)
            OP_U:    calc = {1'b0, acc_reg};
            OP_S: begin
                case (ent.nb)
                    3'd1:    calc = {{25{acc_reg[7]}}, acc_reg[7:0]};
                    3'd2:    calc = {{17{acc_reg[15]}}, acc_reg[15:0]};
                    default: calc = {acc_reg[31], acc_reg};
                endcase
            end
            OP_BITS: calc = {30'd0, shifted[2:0] & ent.mask};
            OP_SEC:  calc = {25'd0, secv};
            OP_DATE: begin
                // FAT date only when the date or time valid flag is set
                if (acc_reg[1:0] != 2'd0) begin
                    calc = {1'b0, year_reg, mon_reg, day_reg, hour_reg, min_reg, sec_reg[5:1]};
                end else begin
                    calc = '0;
                end
            end
            default: calc = {1'b0, acc_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= B_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            st_reg     <= st_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        fid_reg   <= fid_next;
        bidx_reg  <= bidx_next;
        acc_reg   <= acc_next;
        year_reg  <= year_next;
        mon_reg   <= mon_next;
        day_reg   <= day_next;
        hour_reg  <= hour_next;
        min_reg   <= min_next;
        sec_reg   <= sec_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        oval_reg  <= oval_next;
        ofid_reg  <= ofid_next;
        okind_reg <= okind_next;
        ostat_reg <= ostat_next;
        olast_reg <= olast_next;
    end

    always_comb begin
        st_next     = st_reg;
        kind_next   = kind_reg;
        fid_next    = fid_reg;
        bidx_next   = bidx_reg;
        acc_next    = acc_reg;
        year_next   = year_reg;
        mon_next    = mon_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        min_next    = min_reg;
        sec_next    = sec_reg;
        prod_next   = prod_reg;
        neg_next    = neg_reg;
        ovalid_next = ovalid_reg;
        oval_next   = oval_reg;
        ofid_next   = ofid_reg;
        okind_next  = okind_reg;
        ostat_next  = ostat_reg;
        olast_next  = olast_reg;
        pop         = 1'b0;
        case (st_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    pop       = 1'b1;
                    kind_next = q_cmd.kind;
                    fid_next  = '0;
                    bidx_next = 2'd0;
                    acc_next  = 32'd0;
                    if (q_cmd.fail) begin
                        ovalid_next = 1'b1;
                        oval_next   = '0;
                        ofid_next   = '0;
                        okind_next  = q_cmd.kind;
                        ostat_next  = 1'b1;
                        olast_next  = 1'b1;
                        st_next     = B_SEND;
                    end else begin
                        st_next = B_RD;
                    end
                end
            end
            B_RD: begin
                st_next = B_CAP;
            end
            B_CAP: begin
                acc_next[8*bidx_reg +: 8] = rd_data;
                if ({1'b0, bidx_reg} == ent.nb - 3'd1) begin
                    st_next = B_CALC;
                end else begin
                    bidx_next = bidx_reg + 2'd1;
                    st_next   = B_RD;
                end
            end
            B_CALC: begin
                case (ent.cap)
                    CAP_YEAR:  year_next = acc_reg[6:0] - 7'(YEAR_BASE);
                    CAP_MONTH: mon_next  = acc_reg[3:0];
                    CAP_DAY:   day_next  = acc_reg[4:0];
                    CAP_HOUR:  hour_next = acc_reg[4:0];
                    CAP_MIN:   min_next  = acc_reg[5:0];
                    CAP_SEC:   sec_next  = secv[5:0];
                    default:   ;
                endcase
                okind_next = kind_reg;
                ostat_next = 1'b0;
                ofid_next  = fid_reg;
                olast_next = ent.last;
                if (ent.op == OP_DIV) begin
                    prod_next = mag * DIV10_MAGIC;
                    neg_next  = acc_reg[31];
                    st_next   = B_DIV;
                end else begin
                    oval_next   = calc;
                    ovalid_next = 1'b1;
                    st_next     = B_SEND;
                end
            end
            B_DIV: begin
                // truncate toward zero: divide the magnitude, restore the sign
                oval_next   = neg_reg ? (33'd0 - {4'd0, quot}) : {4'd0, quot};
                ovalid_next = 1'b1;
                st_next     = B_SEND;
            end
            B_SEND: begin
                if (m_tready) begin
                    ovalid_next = 1'b0;
                    if (olast_reg) begin
                        st_next = B_IDLE;
                    end else begin
                        fid_next  = fid_reg + 6'd1;
                        bidx_next = 2'd0;
                        acc_next  = 32'd0;
                        st_next   = B_RD;
                    end
                end
            end
            default: begin
                st_next = B_IDLE;
            end
        endcase
    end

    assign idle     = (st_reg == B_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {1'b0, oval_reg, ofid_reg};
    assign m_tuser  = {ostat_reg, okind_reg};
    assign m_tlast  = olast_reg;

endmodule

[rtl/ubx_nav_frame_decoder.sv]
// Top level of the UBX navigation frame decoder: register port, parser, queue, store, field unit.
// Depends on ubxd_pkg, ubxd_front, ubxd_cmd_fifo, ubxd_payload_ram, ubxd_back.
//
// Usage: received bytes enter on the s_ stream, one byte per request, with no framing.
// The parser hunts sync, class, id and length, stores the payload and checks the
// Fletcher-8 sum. After the second checksum byte, or a failing first one, the m_ stream gives
// either one failure result (status set, last set) or every decoded field of the frame, last on
// the final one. Throughput: one byte per cycle while hunting the header or filling the store,
// unless intake stalls as below. A field reads each payload byte it spans through the single
// store read port (B_RD, then B_CAP), is shaped in B_CALC (then B_DIV for the divided lon and
// lat) and is sent from B_SEND. A checksum failure result needs no store read: the field unit
// loads it straight from the request queue. Byte intake stalls only when a payload or checksum
// byte arrives while a field run is pending or in progress, or when the two-entry request
// queue is full; header bytes go on unless the queue is full. When m_tready is low the current
// result holds in its output register. Reset: synchronous, active low; control and
// configuration registers go to their defaults and the parser hunts. No store clearing pass
// is run. The user must write configuration over the APB port only while idle; the block
// itself does not enforce this.
module ubx_nav_frame_decoder #(
    parameter int PAYLOAD_DEPTH = ubxd_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [ubxd_pkg::OUT_TDATA_W-1:0] m_tdata,  // [5:0] field_id, [38:6] value
    output logic [1:0]  m_tuser,   // [0] msg_kind, [1] status
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ubxd_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_wr;
    reg_idx_t   widx, ridx;

    wr_t        wr;
    logic       push, pop, q_full, q_empty, back_idle, run_busy;
    cmd_t       push_cmd, pop_cmd;
    logic [7:0] rd_addr, rd_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign widx   = reg_idx_t'(paddr[4:2]);
    assign ridx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first    <= SYNC_FIRST_RST;
            cfg_reg.sync_second   <= SYNC_SECOND_RST;
            cfg_reg.class_code    <= CLASS_CODE_RST;
            cfg_reg.pvt_id        <= PVT_ID_RST;
            cfg_reg.relpos_id     <= RELPOS_ID_RST;
            cfg_reg.pvt_length    <= PVT_LENGTH_RST;
            cfg_reg.relpos_length <= RELPOS_LENGTH_RST;
        end else if (cfg_wr) begin
            case (widx)
                REG_SYNC_FIRST:    cfg_reg.sync_first    <= pwdata[7:0];
                REG_SYNC_SECOND:   cfg_reg.sync_second   <= pwdata[7:0];
                REG_CLASS_CODE:    cfg_reg.class_code    <= pwdata[7:0];
                REG_PVT_ID:        cfg_reg.pvt_id        <= pwdata[7:0];
                REG_RELPOS_ID:     cfg_reg.relpos_id     <= pwdata[7:0];
                REG_PVT_LENGTH:    cfg_reg.pvt_length    <= pwdata[7:0];
                REG_RELPOS_LENGTH: cfg_reg.relpos_length <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_SYNC_FIRST:    prdata = {24'd0, cfg_reg.sync_first};
            REG_SYNC_SECOND:   prdata = {24'd0, cfg_reg.sync_second};
            REG_CLASS_CODE:    prdata = {24'd0, cfg_reg.class_code};
            REG_PVT_ID:        prdata = {24'd0, cfg_reg.pvt_id};
            REG_RELPOS_ID:     prdata = {24'd0, cfg_reg.relpos_id};
            REG_PVT_LENGTH:    prdata = {24'd0, cfg_reg.pvt_length};
            REG_RELPOS_LENGTH: prdata = {24'd0, cfg_reg.relpos_length};
            default:           prdata = 32'd0;
        endcase
    end

    assign run_busy = !back_idle || !q_empty;

    ubxd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .run_busy (run_busy),
        .q_full   (q_full),
        .wr       (wr),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ubxd_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    ubxd_payload_ram #(.DEPTH(PAYLOAD_DEPTH)) u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ubxd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_cmd    (pop_cmd),
        .pop      (pop),
        .idle     (back_idle),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_store_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> (back_idle && q_empty))
        else $error("payload store written while a field run is pending");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("request queue pushed while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_empty)
        else $error("request queue popped while empty");

    a_fail_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("checksum failure result not marked last");

endmodule

[tb/tb_top.sv]
// Self-checking bench for ubx_nav_frame_decoder: frames of bytes go in on the s_ stream and
// every decoded field or checksum failure on the m_ stream is compared with a frame predictor.
// Depends on ubxd_pkg and the decoder RTL.
module tb_top;
    import ubxd_pkg::*;

    typedef enum logic [1:0] {CFG_RESET, CFG_SHORT, CFG_ODD, CFG_EDGE} cfg_sel_t;
    typedef enum logic [1:0] {FILL_RAND, FILL_ZERO, FILL_ONES, FILL_SEC60} fill_t;
    typedef enum logic [2:0] {
        FL_NONE, FL_CKA, FL_CKB, FL_SYNC_REPEAT, FL_LEN, FL_ID, FL_CLASS
    } flaw_t;
    typedef enum logic [1:0] {W_NONE, W_FAIL, W_FIELDS} want_t;

    typedef struct packed {
        cfg_sel_t cs;
        logic     kind;
        fill_t    fill;
        flaw_t    flaw;
        want_t    want;
    } frame_row_t;

    typedef struct packed {
        logic        kind;
        logic        fail;
        logic [5:0]  fid;
        logic [32:0] value;
        logic        last;
    } field_rec_t;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;  // [5:0] field_id, [38:6] value
    logic [1:0]  m_tuser;    // [0] msg_kind, [1] status
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ubx_nav_frame_decoder uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state
    cfg_t       cur_cfg;
    phase_t     parse_ph;
    logic [7:0] sum_a, sum_b, pay_cnt;
    logic       frame_kind;
    logic [7:0] pay_mem [0:127];

    field_rec_t pending_fields[$];
    logic       emit_kind;
    int         emit_fid;
    int         run_len;
    logic       run_fail;

    int  err_cnt = 0;
    int  cycle_cnt = 0;
    int  bytes_sent = 0;
    bit  tx_gaps = 1;
    bit  rx_gaps = 1;
    bit  hold_req = 0;
    bit  hold_done = 0;

    frame_row_t frame_rows [0:16] = '{
        '{CFG_RESET, 1'b0, FILL_RAND,  FL_NONE,        W_FIELDS},
        '{CFG_SHORT, 1'b0, FILL_ZERO,  FL_NONE,        W_FIELDS},
        '{CFG_SHORT, 1'b0, FILL_SEC60, FL_NONE,        W_FIELDS},
        '{CFG_SHORT, 1'b1, FILL_RAND,  FL_NONE,        W_FIELDS},
        '{CFG_SHORT, 1'b1, FILL_ONES,  FL_NONE,        W_FIELDS},
        '{CFG_SHORT, 1'b0, FILL_RAND,  FL_CKA,         W_FAIL},
        '{CFG_SHORT, 1'b1, FILL_RAND,  FL_CKB,         W_FAIL},
        '{CFG_SHORT, 1'b0, FILL_RAND,  FL_SYNC_REPEAT, W_NONE},
        '{CFG_SHORT, 1'b1, FILL_RAND,  FL_LEN,         W_NONE},
        '{CFG_SHORT, 1'b0, FILL_RAND,  FL_ID,          W_NONE},
        '{CFG_SHORT, 1'b1, FILL_ZERO,  FL_CLASS,       W_NONE},
        '{CFG_ODD,   1'b0, FILL_RAND,  FL_NONE,        W_FIELDS},
        '{CFG_ODD,   1'b1, FILL_RAND,  FL_NONE,        W_NONE},
        '{CFG_ODD,   1'b0, FILL_ONES,  FL_CKB,         W_FAIL},
        '{CFG_EDGE,  1'b0, FILL_ONES,  FL_NONE,        W_FIELDS},
        '{CFG_EDGE,  1'b1, FILL_ZERO,  FL_NONE,        W_FIELDS},
        '{CFG_EDGE,  1'b1, FILL_RAND,  FL_CKA,         W_FAIL}
    };

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- frame predictor ----------------
    function automatic logic [7:0] rb(input int i);
        return (i < 128) ? pay_mem[i] : 8'h00;
    endfunction

    function automatic longint u32(input int o);
        return {32'b0, rb(o + 3), rb(o + 2), rb(o + 1), rb(o)};
    endfunction

    function automatic longint u16(input int o);
        return {48'b0, rb(o + 1), rb(o)};
    endfunction

    function automatic longint s32(input int o);
        logic signed [31:0] t;
        t = {rb(o + 3), rb(o + 2), rb(o + 1), rb(o)};
        return t;
    endfunction

    function automatic longint s16(input int o);
        logic signed [15:0] t;
        t = {rb(o + 1), rb(o)};
        return t;
    endfunction

    function automatic longint s8(input int o);
        logic signed [7:0] t;
        t = rb(o);
        return t;
    endfunction

    task automatic add_field(input longint v);
        field_rec_t r;
        r.kind  = emit_kind;
        r.fail  = 1'b0;
        r.fid   = emit_fid[5:0];
        r.value = v[32:0];
        r.last  = 1'b0;
        pending_fields.push_back(r);
        emit_fid++;
    endtask

    task automatic add_failure();
        field_rec_t r;
        r = '{kind: frame_kind, fail: 1'b1, fid: 6'd0, value: 33'd0, last: 1'b0};
        pending_fields.push_back(r);
        emit_fid = 1;
        run_fail = 1'b1;
    endtask

    task automatic decode_pvt();
        int unsigned yr, mon, dy, hr, mn, sc, vld, f1, f2, dt;
        yr  = u16(4);
        mon = rb(6);
        dy  = rb(7);
        hr  = rb(8);
        mn  = rb(9);
        sc  = rb(10);
        vld = rb(11);
        f1  = rb(21);
        f2  = rb(22);
        if (sc >= 60) sc = 59;
        dt = 0;
        if ((vld & 3) != 0) begin
            dt = (yr - YEAR_BASE) & 'h7f;
            dt = (dt << 4) | (mon & 'hf);
            dt = (dt << 5) | (dy & 'h1f);
            dt = (dt << 5) | (hr & 'h1f);
            dt = (dt << 6) | (mn & 'h3f);
            dt = (dt << 5) | ((sc >> 1) & 'h1f);
        end
        add_field(u32(0));
        add_field(yr);
        add_field(mon);
        add_field(dy);
        add_field(hr);
        add_field(mn);
        add_field(sc);
        add_field(dt);
        for (int k = 0; k < 4; k++) add_field((vld >> k) & 1);
        add_field(u32(12));
        add_field(s32(16));
        add_field(rb(20));
        add_field(f1 & 1);
        add_field((f1 >> 1) & 1);
        add_field((f1 >> 2) & 7);
        add_field((f1 >> 5) & 1);
        add_field((f1 >> 6) & 3);
        add_field((f2 >> 5) & 1);
        add_field((f2 >> 6) & 1);
        add_field((f2 >> 7) & 1);
        add_field(rb(23));
        add_field(s32(24) / 10);
        add_field(s32(28) / 10);
        add_field(s32(32));
        add_field(s32(36));
        add_field(u32(40));
        add_field(u32(44));
        for (int k = 0; k < 5; k++) add_field(s32(48 + 4 * k));
        add_field(u32(68));
        add_field(u32(72));
        add_field(u16(76));
        add_field(rb(78) & 1);
        add_field(s32(84));
        add_field(s16(88));
        add_field(u16(90));
    endtask

    task automatic decode_relpos();
        longint fl;
        fl = u32(60);
        add_field(rb(0));
        add_field(u16(2));
        add_field(u32(4));
        for (int k = 0; k < 5; k++) add_field(s32(8 + 4 * k));
        for (int k = 0; k < 4; k++) add_field(s8(32 + k));
        for (int k = 0; k < 5; k++) add_field(u32(36 + 4 * k));
        add_field(fl & 1);
        add_field((fl >> 1) & 1);
        add_field((fl >> 2) & 1);
        add_field((fl >> 3) & 3);
        for (int k = 5; k < 10; k++) add_field((fl >> k) & 1);
    endtask

    task automatic keep_byte(input logic [7:0] b);
        if (pay_cnt < 128) pay_mem[pay_cnt[6:0]] = b;
        pay_cnt = pay_cnt + 8'd1;
    endtask

    task automatic advance_sums(input logic [7:0] b);
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
    endtask

    task automatic predict_byte(input logic [7:0] b);
        logic [7:0] len;
        int         base;
        len = frame_kind ? cur_cfg.relpos_length : cur_cfg.pvt_length;
        base = pending_fields.size();
        emit_kind = frame_kind;
        emit_fid = 0;
        case (parse_ph)
            PH_SYNC1: parse_ph = (b == cur_cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
            PH_SYNC2: parse_ph = (b == cur_cfg.sync_second) ? PH_CLASS : PH_SYNC1;
            PH_CLASS: begin
                if (b == cur_cfg.class_code) begin
                    parse_ph = PH_ID;
                    pay_cnt = 8'd0;
                    sum_a = b;
                    sum_b = b;
                end else begin
                    parse_ph = PH_SYNC1;
                end
            end
            PH_ID: begin
                if (b == cur_cfg.pvt_id || b == cur_cfg.relpos_id) begin
                    frame_kind = (b == cur_cfg.pvt_id) ? KIND_PVT : KIND_RELPOS;
                    advance_sums(b);
                    parse_ph = PH_LENLO;
                end else begin
                    parse_ph = PH_SYNC1;
                end
            end
            PH_LENLO, PH_LENHI: begin
                if (b == ((parse_ph == PH_LENLO) ? len : 8'd0)) begin
                    advance_sums(b);
                    parse_ph = (parse_ph == PH_LENLO) ? PH_LENHI : PH_PAYLOAD;
                end else begin
                    parse_ph = PH_SYNC1;
                end
            end
            PH_PAYLOAD: begin
                keep_byte(b);
                advance_sums(b);
                if (pay_cnt == len) parse_ph = PH_CKA;
            end
            PH_CKA: begin
                keep_byte(b);
                if (b != sum_a) begin
                    parse_ph = PH_SYNC1;
                    add_failure();
                end else begin
                    parse_ph = PH_CKB;
                end
            end
            PH_CKB: begin
                keep_byte(b);
                parse_ph = PH_SYNC1;
                if (b != sum_b) add_failure();
                else if (frame_kind == KIND_RELPOS) decode_relpos();
                else decode_pvt();
            end
            default: parse_ph = PH_SYNC1;
        endcase
        if (pending_fields.size() > base) begin
            pending_fields[pending_fields.size() - 1].last = 1'b1;
            run_len = pending_fields.size() - base;
        end
    endtask

    // ---------------- drivers ----------------
    task automatic send_byte(input logic [7:0] b);
        if (tx_gaps && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic kind, input fill_t fill, input flaw_t flaw);
        logic [7:0] body [0:259];
        logic [7:0] len, idb, ca, cb;
        int         n;
        len = kind ? cur_cfg.relpos_length : cur_cfg.pvt_length;
        idb = kind ? cur_cfg.relpos_id : cur_cfg.pvt_id;
        n = (len == 0) ? 256 : len;
        if (flaw == FL_LEN) len = len + 8'd1;
        if (flaw == FL_ID) begin
            do idb = $urandom; while (idb == cur_cfg.pvt_id || idb == cur_cfg.relpos_id);
        end
        body[0] = (flaw == FL_CLASS) ? cur_cfg.class_code ^ 8'h01 : cur_cfg.class_code;
        body[1] = idb;
        body[2] = len;
        body[3] = 8'h00;
        for (int i = 0; i < n; i++) begin
            case (fill)
                FILL_ZERO: body[4 + i] = 8'h00;
                FILL_ONES: body[4 + i] = 8'hff;
                default:   body[4 + i] = $urandom;
            endcase
        end
        if (fill == FILL_SEC60 && n > 11) begin
            body[14] = 8'd60;
            body[15] = 8'h03;
        end
        ca = 8'h00;
        cb = 8'h00;
        for (int i = 0; i < n + 4; i++) begin
            ca = ca + body[i];
            cb = cb + ca;
        end
        send_byte(cur_cfg.sync_first);
        if (flaw == FL_SYNC_REPEAT) send_byte(cur_cfg.sync_first);
        send_byte(cur_cfg.sync_second);
        for (int i = 0; i < n + 4; i++) send_byte(body[i]);
        if (flaw == FL_CKA) begin
            send_byte(ca ^ (8'h01 << $urandom_range(0, 7)));
        end else begin
            send_byte(ca);
            send_byte((flaw == FL_CKB) ? cb ^ (8'h01 << $urandom_range(0, 7)) : cb);
        end
    endtask

    // Feed noise until the parser hunts again.
    task automatic settle();
        while (parse_ph != PH_SYNC1) send_byte($urandom);
    endtask

    task automatic wait_drained();
        while (pending_fields.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_wr(input reg_idx_t r, input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {24'b0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        case (r)
            REG_SYNC_FIRST:  cur_cfg.sync_first    = v;
            REG_SYNC_SECOND: cur_cfg.sync_second   = v;
            REG_CLASS_CODE:  cur_cfg.class_code    = v;
            REG_PVT_ID:      cur_cfg.pvt_id        = v;
            REG_RELPOS_ID:   cur_cfg.relpos_id     = v;
            REG_PVT_LENGTH:  cur_cfg.pvt_length    = v;
            default:         cur_cfg.relpos_length = v;
        endcase
    endtask

    task automatic load_config(input cfg_t c);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (30) @(posedge aclk);
        apb_wr(REG_SYNC_FIRST, c.sync_first);
        apb_wr(REG_SYNC_SECOND, c.sync_second);
        apb_wr(REG_CLASS_CODE, c.class_code);
        apb_wr(REG_PVT_ID, c.pvt_id);
        apb_wr(REG_RELPOS_ID, c.relpos_id);
        apb_wr(REG_PVT_LENGTH, c.pvt_length);
        apb_wr(REG_RELPOS_LENGTH, c.relpos_length);
    endtask

    function automatic cfg_t cfg_for(input cfg_sel_t s);
        case (s)
            CFG_SHORT: return '{SYNC_FIRST_RST, SYNC_SECOND_RST, CLASS_CODE_RST, PVT_ID_RST,
                                RELPOS_ID_RST, 8'd12, 8'd4};
            CFG_ODD:   return '{8'h00, 8'hff, 8'hff, 8'h2a, 8'h2a, 8'h03, 8'h01};
            CFG_EDGE:  return '{8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'd5, 8'd7};
            default:   return '{SYNC_FIRST_RST, SYNC_SECOND_RST, CLASS_CODE_RST, PVT_ID_RST,
                                RELPOS_ID_RST, PVT_LENGTH_RST, RELPOS_LENGTH_RST};
        endcase
    endfunction

    function automatic logic [7:0] pick_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 16);
    endfunction

    // ---------------- result side ----------------
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                // hold off long enough for a pending field run to back up into s_tready
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_done = 1;
            end else if (rx_gaps && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        field_rec_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{kind: m_tuser[0], fail: m_tuser[1], fid: m_tdata[5:0],
                    value: m_tdata[38:6], last: m_tlast};
            if (pending_fields.size() == 0) begin
                $display("%0t: unexpected result kind=%0b status=%0b id=%0d value=%h last=%0b",
                         $time, got.kind, got.fail, got.fid, got.value, got.last);
                err_cnt++;
            end else begin
                want = pending_fields.pop_front();
                if (got.kind !== want.kind || got.fail !== want.fail ||
                    got.fid !== want.fid || got.value !== want.value ||
                    got.last !== want.last) begin
                    $display("%0t: expected kind=%0b status=%0b id=%0d value=%h last=%0b",
                             $time, want.kind, want.fail, want.fid, want.value, want.last);
                    $display("%0t: actual   kind=%0b status=%0b id=%0d value=%h last=%0b",
                             $time, got.kind, got.fail, got.fid, got.value, got.last);
                    err_cnt++;
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        cfg_sel_t sel;
        cfg_t     c;
        int       start, pick, want_n;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        cur_cfg  = cfg_for(CFG_RESET);
        parse_ph = PH_SYNC1;
        sum_a = 8'h00;
        sum_b = 8'h00;
        pay_cnt = 8'h00;
        frame_kind = KIND_PVT;
        sel = CFG_RESET;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames; the first full PVT frame fills every store entry later read.
        foreach (frame_rows[i]) begin
            if (frame_rows[i].cs != sel) begin
                sel = frame_rows[i].cs;
                load_config(cfg_for(sel));
            end
            run_len = 0;
            run_fail = 1'b0;
            send_frame(frame_rows[i].kind, frame_rows[i].fill, frame_rows[i].flaw);
            // stall the receiver while the next frames of the same setting keep coming
            if (i == 1) hold_req = 1;
            want_n = (frame_rows[i].want == W_NONE) ? 0 :
                     (frame_rows[i].want == W_FAIL) ? 1 :
                     (frame_rows[i].kind == KIND_RELPOS) ? 26 : 42;
            if (run_len != want_n || run_fail != (frame_rows[i].want == W_FAIL)) begin
                $display("%0t: frame row %0d expected %0d results (fail=%0b), got %0d (fail=%0b)",
                         $time, i, want_n, frame_rows[i].want == W_FAIL, run_len, run_fail);
                err_cnt++;
            end
            settle();
        end

        // Random frames under random settings; the last phase runs without idling.
        for (int ph = 0; ph < 3; ph++) begin
            c.sync_first    = $urandom;
            c.sync_second   = $urandom;
            c.class_code    = $urandom;
            c.pvt_id        = $urandom;
            c.relpos_id     = $urandom;
            c.pvt_length    = pick_len();
            c.relpos_length = pick_len();
            load_config(c);
            if (ph == 2) begin
                tx_gaps = 0;
                rx_gaps = 0;
            end
            start = bytes_sent;
            while (bytes_sent - start < 20) begin
                pick = $urandom_range(0, 19);
                if (pick < 13)
                    send_frame($urandom_range(0, 1),
                               ($urandom_range(0, 5) == 0) ? FILL_SEC60 : FILL_RAND, FL_NONE);
                else if (pick < 15)
                    send_frame($urandom_range(0, 1), FILL_RAND, FL_CKA);
                else if (pick < 17)
                    send_frame($urandom_range(0, 1), FILL_RAND, FL_CKB);
                else if (pick == 17)
                    send_frame($urandom_range(0, 1), FILL_RAND, FL_SYNC_REPEAT);
                else if (pick == 18)
                    send_frame($urandom_range(0, 1), FILL_RAND,
                               flaw_t'($urandom_range(FL_LEN, FL_CLASS)));
                else
                    repeat ($urandom_range(1, 8)) send_byte($urandom);
                settle();
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (60) @(posedge aclk);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
